FILE: rtl/bldc_sensorless_commutator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensorless commutator
// Shorthand for the clocked assertions used inside the state core.
// ----------------------------------------------------------------------------
`ifndef BLDC_SENSORLESS_COMMUTATOR_MACROS_SVH
`define BLDC_SENSORLESS_COMMUTATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Sensorless commutator package
// Payload types, register indexes and the six-step commutation tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DIRECTION       = 2'd0,
      REG_SPEED_COUNT_MAX = 2'd1,
      REG_SPEED_COUNT_MIN = 2'd2
   } reg_index_type;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic [2:0] HALL_RESET = 3'd5;
   localparam logic [2:0] HALL_FG_A  = 3'd1;
   localparam logic [2:0] HALL_FG_B  = 3'd6;
   localparam logic [2:0] STEP_COUNT = 3'd6;

   typedef struct packed {
      logic operation;
      logic comp_out;
   } req_item_type;

   typedef struct packed {
      logic        commutated;
      logic [2:0]  hall_pattern;
      logic        expect_rising;
      logic [15:0] speed_count;
      logic [15:0] step_time;
      logic [19:0] electrical_period;
      logic        period_ready;
      logic        fg_toggle;
      logic        blanking;
   } rsp_item_type;

   typedef struct packed {
      logic        direction;
      logic [15:0] speed_count_max;
      logic [15:0] speed_count_min;
   } cfg_type;

   // Hall pattern driven on each step.
   function automatic logic [2:0] hall_of(input logic [2:0] step);
      logic [2:0] pattern;
      case (step)
         3'd1:    pattern = 3'd4;
         3'd2:    pattern = 3'd6;
         3'd3:    pattern = 3'd2;
         3'd4:    pattern = 3'd3;
         3'd5:    pattern = 3'd1;
         default: pattern = 3'd5;
      endcase
      return pattern;
   endfunction

   // Following step for the given direction.
   function automatic logic [2:0] next_of(input logic dir, input logic [2:0] step);
      logic [2:0] s;
      logic [2:0] n;
      s = (step < STEP_COUNT) ? step : 3'd0;
      if (dir) begin
         n = (s == 3'd0) ? 3'd5 : s - 3'd1;
      end else begin
         n = (s == 3'd5) ? 3'd0 : s + 3'd1;
      end
      return n;
   endfunction

   // Comparator polarity counted as the matching edge on each step.
   function automatic logic rise_of(input logic dir, input logic [2:0] step);
      logic [2:0] s;
      s = (step < STEP_COUNT) ? step : 3'd0;
      return s[0] ^ dir;
   endfunction

endpackage

FILE: rtl/bsc_cfg.sv
// ----------------------------------------------------------------------------
// Sensorless commutator configuration registers
// Holds direction and the clamps of the interval estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_cfg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bsc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bsc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output bsc_pkg::cfg_type                      cfg
);
   import bsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DIRECTION:       cfg_in.direction       = csr_wdata[0];
            REG_SPEED_COUNT_MAX: cfg_in.speed_count_max = csr_wdata;
            REG_SPEED_COUNT_MIN: cfg_in.speed_count_min = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction       <= 1'b0;
         cfg_ff.speed_count_max <= 16'd4000;
         cfg_ff.speed_count_min <= 16'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/bsc_core.sv
// ----------------------------------------------------------------------------
// Sensorless commutator state core
// Commutation state and its update for one accepted item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_core #(
   parameter int unsigned COUNT_WIDTH  = 16,
   parameter int unsigned PERIOD_WIDTH = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  bsc_pkg::req_item_type item,
   input  bsc_pkg::cfg_type      cfg,
   output bsc_pkg::rsp_item_type result
);
   import bsc_pkg::*;

   `include "bldc_sensorless_commutator_macros.svh"

   localparam int unsigned CW    = COUNT_WIDTH;
   localparam int unsigned PW    = PERIOD_WIDTH;
   localparam int unsigned CMP_W = (CW > 16) ? CW : 16;
   localparam int unsigned PX_W  = (PW > 20) ? PW : 20;
   localparam int unsigned PQ_W  = ((CW + 3) > PW) ? (CW + 3) : PW;

   localparam logic [CW-1:0] CNT_ONES = '1;
   localparam logic [PW-1:0] PER_ONES = '1;

   logic          running_ff, running_in;
   logic [2:0]    step_ff, step_in;
   logic [2:0]    hall_ff, hall_in;
   logic          rise_ff, rise_in;
   logic [CW-1:0] est_ff, est_in;
   logic [CW-1:0] phase_ff, phase_in;
   logic [CW-1:0] step_ticks_ff, step_ticks_in;
   logic [CW-1:0] last_step_ff, last_step_in;
   logic [PW-1:0] period_ff, period_in;
   logic [PW-1:0] last_period_ff, last_period_in;
   logic          pflag_ff, pflag_in;
   logic          blank_ff, blank_in;
   logic [CW-1:0] blank_ticks_ff, blank_ticks_in;
   logic [CW-1:0] blank_len_ff, blank_len_in;

   logic            commutated;
   logic            fg;
   logic [CW-1:0]   start_cnt;
   logic [CW+2:0]   start_x6;
   logic [PW-1:0]   start_per;
   logic [CW-1:0]   step_inc;
   logic [PW-1:0]   period_inc;
   logic [CW-1:0]   blank_inc;
   logic [CW-1:0]   phase_inc;
   logic [CW:0]     est_sum;
   logic [CW-1:0]   est_track;
   logic [2:0]      hall_next;

   always_comb begin
      // Start values: the maximum clamp saturated to the counter width.
      start_cnt = (CMP_W'(cfg.speed_count_max) > CMP_W'(CNT_ONES))
                  ? CNT_ONES : CW'(cfg.speed_count_max);
      start_x6  = (CW + 3)'(start_cnt) * (CW + 3)'(6);
      start_per = (PQ_W'(start_x6) > PQ_W'(PER_ONES)) ? PER_ONES : PW'(start_x6);

      step_inc   = (step_ticks_ff == CNT_ONES) ? step_ticks_ff : step_ticks_ff + 1'b1;
      period_inc = (period_ff == PER_ONES) ? period_ff : period_ff + 1'b1;
      blank_inc  = (blank_ticks_ff == CNT_ONES) ? blank_ticks_ff : blank_ticks_ff + 1'b1;
      phase_inc  = (phase_ff == CNT_ONES) ? phase_ff : phase_ff + 1'b1;
      est_sum    = (CW + 1)'(est_ff) + (CW + 1)'(blank_len_ff);

      est_track = est_ff;
      if (item.comp_out == rise_ff) begin
         if (CMP_W'(est_ff) > CMP_W'(cfg.speed_count_min)) begin
            est_track = est_ff - 1'b1;
         end
      end else if ((CMP_W'(est_ff) < CMP_W'(cfg.speed_count_max)) &&
                   (est_ff != CNT_ONES)) begin
         est_track = est_ff + 1'b1;
      end
      hall_next = hall_of(step_ff);

      running_in     = running_ff;
      step_in        = step_ff;
      hall_in        = hall_ff;
      rise_in        = rise_ff;
      est_in         = est_ff;
      phase_in       = phase_ff;
      step_ticks_in  = step_ticks_ff;
      last_step_in   = last_step_ff;
      period_in      = period_ff;
      last_period_in = last_period_ff;
      pflag_in       = pflag_ff;
      blank_in       = blank_ff;
      blank_ticks_in = blank_ticks_ff;
      blank_len_in   = blank_len_ff;
      commutated     = 1'b0;
      fg             = 1'b0;

      if (item.operation == OP_START) begin
         running_in     = 1'b1;
         hall_in        = hall_of(3'd0);
         rise_in        = rise_of(cfg.direction, 3'd0);
         step_in        = next_of(cfg.direction, 3'd0);
         commutated     = 1'b1;
         est_in         = start_cnt;
         last_step_in   = start_cnt;
         last_period_in = start_per;
         blank_in       = 1'b0;
         blank_ticks_in = '0;
         blank_len_in   = '0;
         step_ticks_in  = '0;
         period_in      = '0;
         phase_in       = '0;
      end else if (running_ff) begin
         step_ticks_in = step_inc;
         period_in     = period_inc;
         if (blank_ff) begin
            blank_ticks_in = blank_inc;
            if (blank_inc >= blank_len_ff) begin
               blank_ticks_in = '0;
               blank_in       = 1'b0;
               phase_in       = blank_len_ff;
               est_in         = est_sum[CW] ? CNT_ONES : est_sum[CW-1:0];
            end
         end else begin
            phase_in = phase_inc;
            est_in   = est_track;
            if (phase_inc >= est_track) begin
               hall_in       = hall_next;
               rise_in       = rise_of(cfg.direction, step_ff);
               step_in       = next_of(cfg.direction, step_ff);
               commutated    = 1'b1;
               last_step_in  = step_inc;
               step_ticks_in = '0;
               if (hall_next == HALL_FG_A) begin
                  fg             = 1'b1;
                  last_period_in = period_inc;
                  period_in      = '0;
                  pflag_in       = 1'b1;
               end else if (hall_next == HALL_FG_B) begin
                  fg = 1'b1;
               end
               blank_len_in   = phase_inc >> 2;
               blank_in       = 1'b1;
               blank_ticks_in = '0;
               phase_in       = '0;
            end
         end
      end

      result.commutated        = commutated;
      result.hall_pattern      = hall_in;
      result.expect_rising     = rise_in;
      result.speed_count       = 16'(CMP_W'(est_in));
      result.step_time         = 16'(CMP_W'(last_step_in));
      result.electrical_period = 20'(PX_W'(last_period_in));
      result.period_ready      = pflag_in;
      result.fg_toggle         = fg;
      result.blanking          = blank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         step_ff        <= 3'd0;
         hall_ff        <= HALL_RESET;
         rise_ff        <= 1'b0;
         est_ff         <= '0;
         phase_ff       <= '0;
         step_ticks_ff  <= '0;
         last_step_ff   <= '0;
         period_ff      <= '0;
         last_period_ff <= '0;
         pflag_ff       <= 1'b0;
         blank_ff       <= 1'b0;
         blank_ticks_ff <= '0;
         blank_len_ff   <= '0;
      end else if (step_en) begin
         running_ff     <= running_in;
         step_ff        <= step_in;
         hall_ff        <= hall_in;
         rise_ff        <= rise_in;
         est_ff         <= est_in;
         phase_ff       <= phase_in;
         step_ticks_ff  <= step_ticks_in;
         last_step_ff   <= last_step_in;
         period_ff      <= period_in;
         last_period_ff <= last_period_in;
         pflag_ff       <= pflag_in;
         blank_ff       <= blank_in;
         blank_ticks_ff <= blank_ticks_in;
         blank_len_ff   <= blank_len_in;
      end
   end

   // The phase count restarts on every commutation and is only reloaded when
   // blanking ends, so it must read zero for the whole blanking window.
   `BSC_ASSERT_IMPL(a_blank_phase_zero, clock, reset, blank_ff, phase_ff == '0,
      "phase count not zero during blanking")
   // The step index never leaves the six-step ring.
   `BSC_ASSERT_IMPL(a_step_in_ring, clock, reset, 1'b1, step_ff < STEP_COUNT,
      "step index outside the six-step ring")
   // The period flag can only be set by a commutation onto pattern 1.
   `BSC_ASSERT_IMPL(a_period_on_pattern, clock, reset, $rose(pflag_ff),
      hall_ff == HALL_FG_A, "period latched away from pattern 1")
   // A commutating tick always leaves the block in blanking.
   `BSC_ASSERT_NEXT(a_commutate_blanks, clock, reset,
      step_en && commutated && (item.operation != OP_START), blank_ff,
      "commutation did not start blanking")

endmodule

FILE: rtl/bldc_sensorless_commutator.sv
// ----------------------------------------------------------------------------
// Six-step sensorless BLDC commutator
// Back-EMF driven commutation sequencer with a registered item pipeline.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one item per PWM tick, or a start item that aligns
// the bridge on hall pattern 5 and loads the interval estimate from the
// maximum clamp. Every accepted item yields exactly one transfer on the rsp
// channel, holding the hall pattern now driven together with timing status.
// The item is captured in an input register; the commutation state is then
// updated and the result is written to the output register that drives rsp.
// Throughput is one item per cycle while results are taken; the state update
// is a single pass of counters, compares and a six-entry table lookup.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more item; req_ready falls only when
// both stages are full. The csr port writes the direction and the estimate
// clamps, and is meant to be used while no item is in flight.
// Synchronous reset empties both stages, loads the register defaults and
// puts the commutator in its stopped state on pattern 5; ticks before the
// first start item leave the state untouched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bldc_sensorless_commutator #(
   parameter int unsigned COUNT_WIDTH  = 16,
   parameter int unsigned PERIOD_WIDTH = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bsc_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bsc_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_we,
   input  logic [bsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bsc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bsc_pkg::*;

   cfg_type      cfg;
   rsp_item_type core_result;

   // Input stage.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   // Output stage.
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         step_fire;

   // The state advances whenever the input stage holds an item and the
   // output register is free, or is being emptied in this same cycle.
   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   bsc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bsc_core #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .PERIOD_WIDTH (PERIOD_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

FILE: test/bldc_sensorless_commutator_tb.sv
// ----------------------------------------------------------------------------
// Sensorless commutator testbench
// Streams start and PWM tick items through the commutator with random gaps
// and receiver stalls, and predicts every result transfer with a cycle-free
// model of the six-step sequencer that is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bldc_sensorless_commutator_tb;

   import bsc_pkg::*;

   // Cycles without any transfer on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the deliberate receiver stall that backs the pipeline up.
   localparam int HOLD_CYCLES    = 64;

   // Six-step tables, three bits per step, step zero in the lowest slice.
   localparam logic [17:0] HALL_SEQ = {3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
   localparam logic [17:0] NEXT_CW  = {3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
   localparam logic [17:0] NEXT_CCW = {3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5};
   // Matching comparator level per step, step zero in bit zero.
   localparam logic [5:0]  RISE_CW  = 6'b101010;
   localparam logic [5:0]  RISE_CCW = 6'b010101;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Items waiting to be offered, and results predicted but not yet seen.
   req_item_type tick_backlog[$];
   rsp_item_type predicted_rsp[$];

   int   mismatches   = 0;
   int   results_seen = 0;
   int   idle_cycles  = 0;
   logic no_gaps      = 1'b0;

   // Register copy as the block should hold it, starting from the reset values.
   cfg_type model_cfg = '{direction: 1'b0, speed_count_max: 16'd4000,
                          speed_count_min: 16'd40};

   // Commutation state of the prediction, again from the reset values.
   logic        mdl_running      = 1'b0;
   logic [2:0]  mdl_step         = 3'd0;
   logic [2:0]  mdl_hall         = 3'd5;
   logic        mdl_rise         = 1'b0;
   logic        mdl_period_flag  = 1'b0;
   logic        mdl_blanking     = 1'b0;
   logic [15:0] mdl_est          = '0;
   logic [15:0] mdl_phase        = '0;
   logic [15:0] mdl_step_ticks   = '0;
   logic [15:0] mdl_last_step    = '0;
   logic [15:0] mdl_blank_ticks  = '0;
   logic [15:0] mdl_blank_len    = '0;
   logic [19:0] mdl_period_ticks = '0;
   logic [19:0] mdl_last_period  = '0;

   bldc_sensorless_commutator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Counters in the block saturate rather than wrap.
   function automatic logic [15:0] bump16(input logic [15:0] value);
      return (value == 16'hFFFF) ? value : value + 16'd1;
   endfunction

   // Drives the pattern of the current step, loads its polarity and moves on.
   // Steps six and seven cannot be reached, but would behave as step zero.
   function automatic void apply_next_step();
      logic [2:0] s;
      s        = (mdl_step < STEP_COUNT) ? mdl_step : 3'd0;
      mdl_hall = HALL_SEQ[3*s +: 3];
      mdl_rise = model_cfg.direction ? RISE_CCW[s] : RISE_CW[s];
      mdl_step = model_cfg.direction ? NEXT_CCW[3*s +: 3] : NEXT_CW[3*s +: 3];
   endfunction

   // Advances the commutation state by one accepted item and returns the
   // result transfer that item should produce.
   function automatic rsp_item_type predict_commutation(input req_item_type item);
      rsp_item_type r;
      logic [16:0]  est_sum;
      logic         commutated;
      logic         fg;
      commutated = 1'b0;
      fg         = 1'b0;
      if (item.operation == OP_START) begin
         // A start realigns on pattern 5 whether or not the motor is running;
         // the sticky period flag survives it.
         mdl_running      = 1'b1;
         mdl_step         = 3'd0;
         apply_next_step();
         commutated       = 1'b1;
         mdl_est          = model_cfg.speed_count_max;
         mdl_last_step    = model_cfg.speed_count_max;
         // Six times a 16-bit value always fits the 20-bit period.
         mdl_last_period  = 20'(model_cfg.speed_count_max) * 20'd6;
         mdl_blanking     = 1'b0;
         mdl_blank_ticks  = '0;
         mdl_blank_len    = '0;
         mdl_step_ticks   = '0;
         mdl_period_ticks = '0;
         mdl_phase        = '0;
      end else if (mdl_running) begin
         mdl_step_ticks = bump16(mdl_step_ticks);
         if (mdl_period_ticks != 20'hFFFFF) begin
            mdl_period_ticks = mdl_period_ticks + 20'd1;
         end
         if (mdl_blanking) begin
            // The comparator is not looked at while blanking.
            mdl_blank_ticks = bump16(mdl_blank_ticks);
            if (mdl_blank_ticks >= mdl_blank_len) begin
               est_sum         = {1'b0, mdl_est} + {1'b0, mdl_blank_len};
               mdl_blank_ticks = '0;
               mdl_blanking    = 1'b0;
               mdl_phase       = mdl_blank_len;
               mdl_est         = est_sum[16] ? 16'hFFFF : est_sum[15:0];
            end
         end else begin
            mdl_phase = bump16(mdl_phase);
            // Each clamp is tested on its own, so a minimum above the maximum
            // simply freezes the estimate between the two.
            if (item.comp_out == mdl_rise) begin
               if (mdl_est > model_cfg.speed_count_min) begin
                  mdl_est = mdl_est - 16'd1;
               end
            end else if (mdl_est < model_cfg.speed_count_max) begin
               mdl_est = mdl_est + 16'd1;
            end
            if (mdl_phase >= mdl_est) begin
               apply_next_step();
               commutated     = 1'b1;
               mdl_last_step  = mdl_step_ticks;
               mdl_step_ticks = '0;
               if (mdl_hall == HALL_FG_A) begin
                  fg               = 1'b1;
                  mdl_last_period  = mdl_period_ticks;
                  mdl_period_ticks = '0;
                  mdl_period_flag  = 1'b1;
               end else if (mdl_hall == HALL_FG_B) begin
                  fg = 1'b1;
               end
               mdl_blank_len   = mdl_phase >> 2;
               mdl_blanking    = 1'b1;
               mdl_blank_ticks = '0;
               mdl_phase       = '0;
            end
         end
      end
      r.commutated        = commutated;
      r.hall_pattern      = mdl_hall;
      r.expect_rising     = mdl_rise;
      r.speed_count       = mdl_est;
      r.step_time         = mdl_last_step;
      r.electrical_period = mdl_last_period;
      r.period_ready      = mdl_period_flag;
      r.fg_toggle         = fg;
      r.blanking          = mdl_blanking;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [19:0] got,
                              input logic [19:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, should be %0d", field, got, want));
      end
   endtask

   function automatic req_item_type make_req(input logic op, input logic comp);
      req_item_type item;
      item.operation = op;
      item.comp_out  = comp;
      return item;
   endfunction

   // Register writes happen only while the block is idle, so the prediction
   // can take the new value at once.
   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_DIRECTION:       model_cfg.direction       = value[0];
         REG_SPEED_COUNT_MAX: model_cfg.speed_count_max = value;
         REG_SPEED_COUNT_MIN: model_cfg.speed_count_min = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued item has been taken and every result has come
   // back, then idles with the two-stage pipeline empty before returning.
   task automatic drain();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Queues a stretch of PWM ticks whose comparator level holds for random
   // runs, with the occasional start item dropped in.
   task automatic queue_ticks(input int count, input int flip_pct,
                              input int start_permille);
      logic comp;
      comp = 1'($urandom_range(0, 1));
      repeat (count) begin
         if ($urandom_range(0, 999) < start_permille) begin
            tick_backlog.push_back(make_req(OP_START, 1'($urandom_range(0, 1))));
         end else begin
            if ($urandom_range(0, 99) < flip_pct) begin
               comp = ~comp;
            end
            tick_backlog.push_back(make_req(OP_TICK, comp));
         end
      end
   endtask

   // Input side: offers the backlog one item at a time, holding each item
   // steady until its transfer, and predicts the result of every transfer.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(predict_commutation(req_item));
         end
         if (req_valid && !req_ready) begin
            // Stalled: the item stays on the channel unchanged.
         end else if (tick_backlog.size() != 0 &&
                      (no_gaps || $urandom_range(0, 99) >= 27)) begin
            req_item  <= tick_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: checks each transfer against the oldest prediction. Twice
   // in the run it stops taking results for a long stretch while the input
   // side keeps offering, so both pipeline stages fill and req_ready drops.
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      int           hold_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("result transfer with no item outstanding");
            end else begin
               want = predicted_rsp.pop_front();
               check_field("commutated", rsp_item.commutated, want.commutated);
               check_field("hall_pattern", rsp_item.hall_pattern, want.hall_pattern);
               check_field("expect_rising", rsp_item.expect_rising, want.expect_rising);
               check_field("speed_count", rsp_item.speed_count, want.speed_count);
               check_field("step_time", rsp_item.step_time, want.step_time);
               check_field("electrical_period", rsp_item.electrical_period,
                           want.electrical_period);
               check_field("period_ready", rsp_item.period_ready, want.period_ready);
               check_field("fg_toggle", rsp_item.fg_toggle, want.fg_toggle);
               check_field("blanking", rsp_item.blanking, want.blanking);
            end
            results_seen++;
            if (results_seen == 200 || results_seen == 900) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_gaps || $urandom_range(0, 99) >= 27;
         end
      end
   end

   // Gives up if neither channel has moved for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [15:0] count_max;
      logic [15:0] count_min;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ticks that arrive before any start leave the state alone.
      tick_backlog.push_back(make_req(OP_TICK, 1'b0));
      tick_backlog.push_back(make_req(OP_TICK, 1'b1));
      drain();

      // A short estimate so that commutations come quickly, clockwise. The
      // comparator level on the start item is ignored; a second start while
      // running realigns the bridge.
      write_reg(REG_DIRECTION, 16'd0);
      write_reg(REG_SPEED_COUNT_MAX, 16'd3);
      write_reg(REG_SPEED_COUNT_MIN, 16'd1);
      tick_backlog.push_back(make_req(OP_START, 1'b1));
      for (int i = 0; i < 10; i++) begin
         tick_backlog.push_back(make_req(OP_TICK, 1'(10'b1011010011 >> i)));
      end
      tick_backlog.push_back(make_req(OP_START, 1'b0));
      tick_backlog.push_back(make_req(OP_TICK, 1'b0));
      tick_backlog.push_back(make_req(OP_TICK, 1'b1));
      drain();

      // Direction flipped while running, with the minimum above the maximum.
      write_reg(REG_DIRECTION, 16'd1);
      write_reg(REG_SPEED_COUNT_MAX, 16'd1);
      write_reg(REG_SPEED_COUNT_MIN, 16'hFFFF);
      for (int i = 0; i < 6; i++) begin
         tick_backlog.push_back(make_req(OP_TICK, 1'(i % 2 == 0)));
      end
      tick_backlog.push_back(make_req(OP_START, 1'b1));
      tick_backlog.push_back(make_req(OP_TICK, 1'b0));
      tick_backlog.push_back(make_req(OP_TICK, 1'b1));
      tick_backlog.push_back(make_req(OP_TICK, 1'b1));
      drain();

      // Random phases, mostly short estimates so that the sequence turns
      // many times per phase. Most phases open with a start; the rest carry
      // on from where the previous one stopped under the new settings.
      for (int phase = 0; phase < 26; phase++) begin
         case ($urandom_range(0, 9))
            0: begin
               count_max = 16'hFFFF;
               count_min = 16'($urandom_range(1, 16'hFFFF));
            end
            1: begin
               count_max = 16'($urandom_range(1, 30));
               count_min = 16'($urandom_range(count_max, 16'hFFFF));
            end
            default: begin
               count_max = 16'($urandom_range(1, 40));
               count_min = 16'($urandom_range(1, count_max));
            end
         endcase
         write_reg(REG_DIRECTION, 16'($urandom_range(0, 1)));
         write_reg(REG_SPEED_COUNT_MAX, count_max);
         write_reg(REG_SPEED_COUNT_MIN, count_min);
         if ($urandom_range(0, 99) < 70) begin
            tick_backlog.push_back(make_req(OP_START, 1'($urandom_range(0, 1))));
         end
         queue_ticks(52, $urandom_range(5, 60), 15);
         drain();
      end

      // A closing run with no gaps on either side and a short estimate, so
      // that transfers follow on every cycle while the sequence keeps turning.
      no_gaps <= 1'b1;
      write_reg(REG_DIRECTION, 16'($urandom_range(0, 1)));
      write_reg(REG_SPEED_COUNT_MAX, 16'd8);
      write_reg(REG_SPEED_COUNT_MIN, 16'd2);
      tick_backlog.push_back(make_req(OP_START, 1'b0));
      queue_ticks(40, 50, 0);
      drain();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_cfg.sv
rtl/bsc_core.sv
rtl/bldc_sensorless_commutator.sv
test/bldc_sensorless_commutator_tb.sv
